// ----- rtl/core/bcpa_pkg.sv -----
package bcpa_pkg;

    localparam int DEF_PALETTE_ENTRIES = 256;

    localparam int COLOR_W  = 24;
    localparam int CHAN_W   = 8;
    localparam int SPEED_W  = 13;
    localparam int POS_W    = 17;
    localparam int LEVEL_W  = 16;
    localparam int LV_W     = 13;
    localparam int CFG_IDX_W = 3;

    // shared multiplier operand and accumulator widths, sized for the largest palette
    localparam int OPA_W = 24;
    localparam int OPB_W = 21;
    localparam int ACC_W = OPA_W + OPB_W;

    localparam logic [POS_W-1:0] POS_ONE   = 17'h10000;
    localparam logic [LV_W-1:0]  LEVEL_ONE = 13'd4096;
    localparam int               LEVEL_FRAC = 12;
    localparam int               POS_FRAC   = 16;

    localparam logic [COLOR_W-1:0] RST_LOW_START  = 24'hFF0000;
    localparam logic [COLOR_W-1:0] RST_HIGH_START = 24'h00FF00;
    localparam logic [COLOR_W-1:0] RST_LOW_END    = 24'h808000;
    localparam logic [COLOR_W-1:0] RST_HIGH_END   = 24'hFF00FF;
    localparam logic [SPEED_W-1:0] RST_SPEED      = 13'd131;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_END    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 3'd4;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // shared unit operations
    localparam logic [1:0] OP_NOP = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_MAC = 2'd2;

    typedef struct packed {
        logic                      mode;
        logic signed [LEVEL_W-1:0] level;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_out_item;

    typedef struct packed {
        logic [1:0] op;
    } t_arith_ctl;

endpackage

// ----- rtl/core/bcpa_arith.sv -----
module bcpa_arith (
    input  logic                               i_clk,
    input  bcpa_pkg::t_arith_ctl               i_ctl,
    input  logic [bcpa_pkg::OPA_W-1:0]         i_opa,
    input  logic [bcpa_pkg::OPB_W-1:0]         i_opb,
    output logic [bcpa_pkg::ACC_W-1:0]         o_acc
);

    logic [bcpa_pkg::ACC_W-1:0] r_acc;
    logic [bcpa_pkg::ACC_W-1:0] prod;

    always_comb begin
        prod = bcpa_pkg::ACC_W'(i_opa) * bcpa_pkg::ACC_W'(i_opb);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            bcpa_pkg::OP_MUL: begin
                r_acc <= prod;
            end
            bcpa_pkg::OP_MAC: begin
                r_acc <= r_acc + prod;
            end
            default: begin
            end
        endcase
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/core/bilinear_color_palette_animator.sv -----
// lookup: one request at a time, the next request taken once the result is loaded; one
// shared multiply-accumulate unit does the index product, then per color channel 6 blend
// products and one reciprocal product that divides by 65536 * palette entries; an
// unaccepted result holds the next
// tick: updates the position, no result
// reset (synchronous, active low) restores the default colors and speed, position zero
module bilinear_color_palette_animator #(
    parameter int PALETTE_ENTRIES = bcpa_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bcpa_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bcpa_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bcpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bcpa_pkg::COLOR_W-1:0]        i_cfg_data
);

    localparam int EW    = $clog2(PALETTE_ENTRIES + 1);
    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int DV_W  = bcpa_pkg::CHAN_W + EW;
    // rounded-up reciprocal, exact for every scaled numerator below 2^(8 + log2 entries)
    localparam int RSH   = bcpa_pkg::CHAN_W + 2 * $clog2(PALETTE_ENTRIES);
    localparam logic [63:0] RECIP =
        ((64'd1 << RSH) + 64'(PALETTE_ENTRIES - 1)) / 64'(PALETTE_ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_IDX  = 2'd1;
    localparam logic [1:0] S_MAC  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [1:0] LAST_CH = 2'd2;
    localparam logic [2:0] LAST_K  = 3'd6;

    logic [bcpa_pkg::COLOR_W-1:0] r_low_start, r_high_start, r_low_end, r_high_end;
    logic [bcpa_pkg::SPEED_W-1:0] r_speed;
    logic [bcpa_pkg::POS_W-1:0]   r_pos;
    logic                         r_down;

    logic [1:0]                   r_state, n_state;
    logic [1:0]                   r_ch;
    logic [2:0]                   r_k;
    logic [bcpa_pkg::LV_W-1:0]    r_lv;
    logic [IDX_W-1:0]             r_idx;
    logic [bcpa_pkg::OPA_W-1:0]   r_a, r_b;
    logic [2*bcpa_pkg::CHAN_W-1:0] r_quot;
    logic                         r_out_valid;
    bcpa_pkg::t_out_item          r_out;

    bcpa_pkg::t_arith_ctl         ctl;
    logic [bcpa_pkg::OPA_W-1:0]   opa;
    logic [bcpa_pkg::OPB_W-1:0]   opb;
    logic [bcpa_pkg::ACC_W-1:0]   acc;

    logic                         in_fire;
    logic                         out_load;
    logic [bcpa_pkg::POS_W-1:0]   inv_pos;
    logic [EW-1:0]                inv_idx;
    logic [bcpa_pkg::POS_W:0]     pos_up;
    logic [bcpa_pkg::LV_W-1:0]    lv_clamp;

    function automatic logic [bcpa_pkg::CHAN_W-1:0] chan_of(
        input logic [bcpa_pkg::COLOR_W-1:0] rgb,
        input logic [1:0]                   ch
    );
        logic [bcpa_pkg::CHAN_W-1:0] v;
        case (ch)
            2'd0:    v = rgb[23:16];
            2'd1:    v = rgb[15:8];
            default: v = rgb[7:0];
        endcase
        return v;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    assign inv_pos = bcpa_pkg::POS_ONE - r_pos;
    assign inv_idx = EW'(PALETTE_ENTRIES) - EW'(r_idx);
    assign pos_up  = {1'b0, r_pos} + (bcpa_pkg::POS_W + 1)'(r_speed);

    always_comb begin
        if (i_in_data.level[bcpa_pkg::LEVEL_W-1]) begin
            lv_clamp = '0;
        end else if (i_in_data.level > $signed(bcpa_pkg::LEVEL_W'(bcpa_pkg::LEVEL_ONE))) begin
            lv_clamp = bcpa_pkg::LEVEL_ONE;
        end else begin
            lv_clamp = i_in_data.level[bcpa_pkg::LV_W-1:0];
        end
    end

    // operand select for the shared unit
    always_comb begin
        ctl.op   = bcpa_pkg::OP_NOP;
        opa      = '0;
        opb      = '0;
        unique case (r_state)
            S_IDX: begin
                ctl.op = bcpa_pkg::OP_MUL;
                opa    = bcpa_pkg::OPA_W'(r_lv);
                opb    = bcpa_pkg::OPB_W'(PALETTE_ENTRIES - 1);
            end
            S_MAC: begin
                case (r_k)
                    3'd0: begin
                        ctl.op = bcpa_pkg::OP_MUL;
                        opa    = bcpa_pkg::OPA_W'(chan_of(r_low_start, r_ch));
                        opb    = bcpa_pkg::OPB_W'(inv_pos);
                    end
                    3'd1: begin
                        ctl.op = bcpa_pkg::OP_MAC;
                        opa    = bcpa_pkg::OPA_W'(chan_of(r_low_end, r_ch));
                        opb    = bcpa_pkg::OPB_W'(r_pos);
                    end
                    3'd2: begin
                        ctl.op = bcpa_pkg::OP_MUL;
                        opa    = bcpa_pkg::OPA_W'(chan_of(r_high_start, r_ch));
                        opb    = bcpa_pkg::OPB_W'(inv_pos);
                    end
                    3'd3: begin
                        ctl.op = bcpa_pkg::OP_MAC;
                        opa    = bcpa_pkg::OPA_W'(chan_of(r_high_end, r_ch));
                        opb    = bcpa_pkg::OPB_W'(r_pos);
                    end
                    3'd4: begin
                        ctl.op = bcpa_pkg::OP_MUL;
                        opa    = r_a;
                        opb    = bcpa_pkg::OPB_W'(inv_idx);
                    end
                    3'd5: begin
                        ctl.op = bcpa_pkg::OP_MAC;
                        opa    = r_b;
                        opb    = bcpa_pkg::OPB_W'(r_idx);
                    end
                    default: begin
                        // numerator scaled down by the position weight, times 1/entries
                        ctl.op = bcpa_pkg::OP_MUL;
                        opa    = bcpa_pkg::OPA_W'(RECIP);
                        opb    = bcpa_pkg::OPB_W'(acc[bcpa_pkg::POS_FRAC +: DV_W]);
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    bcpa_arith u_arith (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_opa  (opa),
        .i_opb  (opb),
        .o_acc  (acc)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && i_in_data.mode == bcpa_pkg::MODE_LOOKUP) begin
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                n_state = S_MAC;
            end
            S_MAC: begin
                if (r_k == LAST_K) begin
                    n_state = (r_ch == LAST_CH) ? S_OUT : S_MAC;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_pos        <= '0;
            r_down       <= 1'b0;
            r_low_start  <= bcpa_pkg::RST_LOW_START;
            r_high_start <= bcpa_pkg::RST_HIGH_START;
            r_low_end    <= bcpa_pkg::RST_LOW_END;
            r_high_end   <= bcpa_pkg::RST_HIGH_END;
            r_speed      <= bcpa_pkg::RST_SPEED;
            r_ch         <= '0;
            r_k          <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    bcpa_pkg::CFG_LOW_START:  r_low_start  <= i_cfg_data;
                    bcpa_pkg::CFG_HIGH_START: r_high_start <= i_cfg_data;
                    bcpa_pkg::CFG_LOW_END:    r_low_end    <= i_cfg_data;
                    bcpa_pkg::CFG_HIGH_END:   r_high_end   <= i_cfg_data;
                    bcpa_pkg::CFG_SPEED:      r_speed      <= i_cfg_data[bcpa_pkg::SPEED_W-1:0];
                    default: begin
                    end
                endcase
            end

            // animation tick, reverse only when the step would pass an end
            if (in_fire && i_in_data.mode == bcpa_pkg::MODE_TICK) begin
                if (r_down) begin
                    if (bcpa_pkg::POS_W'(r_speed) > r_pos) begin
                        r_pos  <= '0;
                        r_down <= 1'b0;
                    end else begin
                        r_pos <= r_pos - bcpa_pkg::POS_W'(r_speed);
                    end
                end else begin
                    if (pos_up > (bcpa_pkg::POS_W + 1)'(bcpa_pkg::POS_ONE)) begin
                        r_pos  <= bcpa_pkg::POS_ONE;
                        r_down <= 1'b1;
                    end else begin
                        r_pos <= pos_up[bcpa_pkg::POS_W-1:0];
                    end
                end
            end

            if (in_fire) begin
                r_ch <= '0;
                r_k  <= '0;
            end
            if (r_state == S_MAC) begin
                r_k <= (r_k == LAST_K) ? '0 : r_k + 3'd1;
                if (r_k == LAST_K) begin
                    r_ch <= r_ch + 2'd1;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_lv <= lv_clamp;
        end
        // index is left in the accumulator by the idx product
        if (r_state == S_MAC && r_ch == '0 && r_k == '0) begin
            r_idx <= acc[bcpa_pkg::LEVEL_FRAC +: IDX_W];
        end
        // previous channel's quotient product is still in the accumulator
        if (r_state == S_MAC && r_ch != '0 && r_k == '0) begin
            r_quot <= {r_quot[bcpa_pkg::CHAN_W-1:0], acc[RSH +: bcpa_pkg::CHAN_W]};
        end
        if (r_state == S_MAC && r_k == 3'd2) begin
            r_a <= acc[bcpa_pkg::OPA_W-1:0];
        end
        if (r_state == S_MAC && r_k == 3'd4) begin
            r_b <= acc[bcpa_pkg::OPA_W-1:0];
        end
        if (out_load) begin
            r_out <= bcpa_pkg::t_out_item'({r_quot, acc[RSH +: bcpa_pkg::CHAN_W]});
        end
    end

endmodule
